// File: rtl/core/wiegand_bit_receiver_assert.svh
// Assertion macros for the Wiegand receiver.
`ifndef WIEGAND_BIT_RECEIVER_ASSERT_SVH
`define WIEGAND_BIT_RECEIVER_ASSERT_SVH

`ifndef SYNTHESIS

`define WBR_ASSERT_NOW(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("wiegand receiver assertion failed");

`define WBR_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("wiegand receiver assertion failed");

`else

`define WBR_ASSERT_NOW(label, clk_s, rst_s, ante, cons)
`define WBR_ASSERT_NEXT(label, clk_s, rst_s, ante, cons)

`endif

`endif

// File: rtl/core/wbr_pkg.sv
package wbr_pkg;

  localparam int MAX_BYTES_DEF = 32;
  localparam int MAX_RESULTS   = 32;
  localparam int CNT_W         = 6;

  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_DATA0  = 3'd1;
  localparam logic [2:0] OP_DATA1  = 3'd2;
  localparam logic [2:0] OP_READ   = 3'd3;
  localparam logic [2:0] OP_STATUS = 3'd4;

  localparam logic REG_MIN_GAP = 1'b0;
  localparam logic REG_TIMEOUT = 1'b1;

  localparam logic [15:0] MIN_GAP_RST = 16'd1000;
  localparam logic [15:0] TIMEOUT_RST = 16'd3000;
  localparam logic [15:0] GAP_MAX     = 16'hFFFF;

  typedef struct packed {
    logic [2:0] op;
    logic [5:0] read_limit;
  } in_item_t;

  typedef struct packed {
    logic [8:0] bit_count;
    logic [7:0] data_byte;
    logic [4:0] byte_index;
    logic       last;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_LOAD
  } state_t;

endpackage

// File: rtl/core/wiegand_bit_receiver.sv
// Wiegand receiver.
// Input requests (in_valid/in_ready, in_data) carry a tick, a DATA0 or DATA1
// pulse, a frame read or a status query. Results leave on out_valid/out_ready
// with out_data; the final result of a read or query has last set.
// Ticks and pulses give no result; they are taken every cycle while no read
// streams, also while a result waits at the output.
// A status query, or a read with no frame pending, gives one result in the
// output register in the cycle after the request.
// A read of a pending frame streams its bytes: each is fetched through the
// registered read port of the byte store, then loaded into the output
// register once the output is free. No request is taken until the last byte
// is loaded. A pulse that opens a frame or keeps min_bit_gap, with room left,
// shifts a bit into the current byte register; a full byte is then stored.
// Reset empties the buffer, saturates the gap counter and loads the default
// min_bit_gap and frame_timeout; no clearing pass is needed.
// When the receiver stalls, the result holds and reads and queries wait.
// Registers: min_bit_gap at byte address 0, frame_timeout at 4.
`include "wiegand_bit_receiver_assert.svh"

module wiegand_bit_receiver #(
  parameter int MAX_BYTES = wbr_pkg::MAX_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  wbr_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output wbr_pkg::out_item_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int BW  = $clog2(MAX_BYTES * 8 + 1);
  localparam int SW  = BW - 3;
  localparam int AW  = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int CAP = (MAX_BYTES < wbr_pkg::MAX_RESULTS) ? MAX_BYTES : wbr_pkg::MAX_RESULTS;
  localparam logic [BW-1:0] BITS_MAX = BW'(MAX_BYTES * 8);

  wbr_pkg::state_t state_r, state_nxt;

  logic [15:0]               min_gap_r, timeout_r;
  logic [15:0]               gap_r, gap_nxt;
  logic [BW-1:0]             bits_r, bits_nxt;
  logic [7:0]                cur_r, cur_nxt;
  logic [7:0]                cur_shift;
  logic [7:0]                mem [MAX_BYTES];
  logic                      mem_we;
  logic [AW-1:0]             mem_waddr;
  logic [7:0]                rd_data_r;
  logic [4:0]                idx_r, idx_nxt;
  logic [wbr_pkg::CNT_W-1:0] n_r, n_nxt;
  logic                      out_valid_r, out_valid_nxt;
  wbr_pkg::out_item_t        out_r, out_nxt;

  logic          in_fire, out_free, pending, makes_result, is_pulse;
  logic          take_bit, last_byte, load_byte, read_start, cfg_write;
  logic [SW-1:0] cur_slot;
  logic [6:0]    lim7, cand;

  assign in_fire      = in_valid && in_ready;
  assign out_free     = !out_valid_r || out_ready;
  assign pending      = (bits_r != '0) && (gap_r > timeout_r);
  assign makes_result = (in_data.op == wbr_pkg::OP_READ) || (in_data.op == wbr_pkg::OP_STATUS);
  assign is_pulse     = (in_data.op == wbr_pkg::OP_DATA0) || (in_data.op == wbr_pkg::OP_DATA1);
  assign cur_slot     = bits_r[BW-1:3];
  assign take_bit     = ((bits_r == '0) || (gap_r >= min_gap_r)) && (bits_r < BITS_MAX);
  assign cur_shift    = {cur_r[6:0], in_data.op == wbr_pkg::OP_DATA1};
  assign last_byte    = (wbr_pkg::CNT_W'(idx_r) + wbr_pkg::CNT_W'(1)) == n_r;
  assign read_start   = in_fire && (in_data.op == wbr_pkg::OP_READ) && pending;
  assign cfg_write    = psel && penable && pwrite;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign pready    = 1'b1;

  always_comb begin
    unique case (paddr[2])
      wbr_pkg::REG_MIN_GAP: prdata = {16'b0, min_gap_r};
      wbr_pkg::REG_TIMEOUT: prdata = {16'b0, timeout_r};
      default:              prdata = '0;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_ready  = 1'b0;
    load_byte = 1'b0;
    unique case (state_r)
      wbr_pkg::ST_IDLE:  in_ready  = out_free || !makes_result;
      wbr_pkg::ST_FETCH: in_ready  = 1'b0;
      wbr_pkg::ST_LOAD:  load_byte = out_free;
      default:           in_ready  = 1'b0;
    endcase
  end

  // FSM next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      wbr_pkg::ST_IDLE: begin
        if (read_start) begin
          state_nxt = wbr_pkg::ST_FETCH;
        end
      end
      wbr_pkg::ST_FETCH: state_nxt = wbr_pkg::ST_LOAD;
      wbr_pkg::ST_LOAD: begin
        if (load_byte) begin
          state_nxt = last_byte ? wbr_pkg::ST_IDLE : wbr_pkg::ST_FETCH;
        end
      end
      default: state_nxt = wbr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    lim7 = (in_data.read_limit == '0) ? 7'd1 : 7'(in_data.read_limit);
    cand = 7'(cur_slot) + 7'd1;
    if (cand > lim7) begin
      cand = lim7;
    end
    if (cand > 7'(CAP)) begin
      cand = 7'(CAP);
    end
  end

  always_comb begin
    gap_nxt       = gap_r;
    bits_nxt      = bits_r;
    cur_nxt       = cur_r;
    mem_we        = 1'b0;
    mem_waddr     = AW'(cur_slot);
    idx_nxt       = idx_r;
    n_nxt         = n_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    if (in_fire) begin
      if (in_data.op == wbr_pkg::OP_TICK) begin
        gap_nxt = (gap_r == wbr_pkg::GAP_MAX) ? gap_r : gap_r + 16'd1;
      end else if (is_pulse) begin
        gap_nxt = '0;
        if (take_bit) begin
          bits_nxt = bits_r + BW'(1);
          if (bits_r[2:0] == 3'b111) begin
            mem_we  = 1'b1;
            cur_nxt = '0;
          end else begin
            cur_nxt = cur_shift;
          end
        end
      end else if (read_start) begin
        idx_nxt = '0;
        n_nxt   = wbr_pkg::CNT_W'(cand);
      end else if (makes_result) begin
        out_valid_nxt       = 1'b1;
        out_nxt.bit_count   = (pending && (in_data.op == wbr_pkg::OP_STATUS)) ? 9'(bits_r) : 9'd0;
        out_nxt.data_byte   = '0;
        out_nxt.byte_index  = '0;
        out_nxt.last        = 1'b1;
      end
    end
    if (load_byte) begin
      out_valid_nxt      = 1'b1;
      out_nxt.bit_count  = 9'(bits_r);
      out_nxt.data_byte  = (7'(idx_r) == 7'(cur_slot)) ? cur_r : rd_data_r;
      out_nxt.byte_index = idx_r;
      out_nxt.last       = last_byte;
      idx_nxt            = idx_r + 5'd1;
      if (last_byte) begin
        bits_nxt = '0;
        cur_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= cur_shift;
    end
    rd_data_r <= mem[AW'(idx_r)];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wbr_pkg::ST_IDLE;
      min_gap_r   <= wbr_pkg::MIN_GAP_RST;
      timeout_r   <= wbr_pkg::TIMEOUT_RST;
      gap_r       <= wbr_pkg::GAP_MAX;
      bits_r      <= '0;
      cur_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      gap_r       <= gap_nxt;
      bits_r      <= bits_nxt;
      cur_r       <= cur_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_write && (paddr[2] == wbr_pkg::REG_MIN_GAP)) begin
        min_gap_r <= pwdata[15:0];
      end
      if (cfg_write && (paddr[2] == wbr_pkg::REG_TIMEOUT)) begin
        timeout_r <= pwdata[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    n_r   <= n_nxt;
    out_r <= out_nxt;
  end

  `WBR_ASSERT_NOW(a_bits_bound, clk, rst_n, 1'b1, bits_r <= BITS_MAX)
  `WBR_ASSERT_NEXT(a_fetch_to_load, clk, rst_n, state_r == wbr_pkg::ST_FETCH, state_r == wbr_pkg::ST_LOAD)
  `WBR_ASSERT_NEXT(a_last_clears, clk, rst_n, load_byte && last_byte, bits_r == '0 && out_r.last)
  `WBR_ASSERT_NEXT(a_read_streams, clk, rst_n, read_start, state_r == wbr_pkg::ST_FETCH && idx_r == '0)

endmodule

// File: sim/wiegand_bit_receiver_tb.sv
`timescale 1ns / 1ps

module wiegand_bit_receiver_tb;

  localparam int         FRAME_BYTES = wbr_pkg::MAX_BYTES_DEF;
  localparam int         STALL_LIMIT = 5000;
  localparam int         TICK_CAP    = 3;
  localparam int         RAND_ITEMS  = 100;
  localparam int         QUIET_AFTER = 75;
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam logic [5:0] LIMIT_MAX   = 6'd63;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  wbr_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_ready;
  wbr_pkg::out_item_t out_data;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  logic [15:0]        gap_min_q;
  logic [15:0]        timeout_q;
  logic [15:0]        idle_ticks;
  logic [8:0]         bits_held_q;
  logic [7:0]         frame_q [FRAME_BYTES];
  wbr_pkg::out_item_t expected_q [$];
  wbr_pkg::in_item_t  request_q [$];
  int                 sent_cnt;
  int                 taken_cnt;
  int                 errors;
  int                 stuck_cycles;
  int                 hold_in;
  int                 hold_out;
  bit                 in_taken;
  bit                 quiet;

  wiegand_bit_receiver dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial clk = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit frame_ready();
    return bits_held_q != 0 && idle_ticks > timeout_q;
  endfunction

  task automatic predict_request(input wbr_pkg::in_item_t r);
    int                 n;
    int                 lim;
    wbr_pkg::out_item_t res;
    res = '0;
    case (r.op)
      wbr_pkg::OP_TICK: begin
        if (idle_ticks != wbr_pkg::GAP_MAX) idle_ticks++;
      end
      wbr_pkg::OP_DATA0, wbr_pkg::OP_DATA1: begin
        if ((bits_held_q == 0 || idle_ticks >= gap_min_q) && bits_held_q / 8 < FRAME_BYTES) begin
          frame_q[bits_held_q / 8] = {frame_q[bits_held_q / 8][6:0], r.op == wbr_pkg::OP_DATA1};
          bits_held_q++;
        end
        idle_ticks = '0;
      end
      wbr_pkg::OP_READ: begin
        if (!frame_ready()) begin
          res.last = 1'b1;
          expected_q.push_back(res);
        end else begin
          n = bits_held_q / 8 + 1;
          lim = (r.read_limit == 0) ? 1 : r.read_limit;
          if (n > lim) n = lim;
          if (n > FRAME_BYTES) n = FRAME_BYTES;
          for (int i = 0; i < n; i++) begin
            res.bit_count = bits_held_q;
            res.data_byte = frame_q[i];
            res.byte_index = 5'(i);
            res.last = (i == n - 1);
            expected_q.push_back(res);
          end
          foreach (frame_q[i]) frame_q[i] = '0;
          bits_held_q = '0;
        end
      end
      wbr_pkg::OP_STATUS: begin
        res.bit_count = frame_ready() ? bits_held_q : 9'd0;
        res.last = 1'b1;
        expected_q.push_back(res);
      end
      default: begin
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                 input logic [31:0] want_v);
    errors++;
    $display("%0t mismatch %s: got %0h, want %0h", $time, what, got_v, want_v);
  endtask

  task automatic check_result(input wbr_pkg::out_item_t got);
    wbr_pkg::out_item_t want;
    if (expected_q.size() == 0) begin
      report_mismatch("result with none pending", 32'(got), 32'd0);
    end else begin
      want = expected_q.pop_front();
      if (got.bit_count !== want.bit_count)
        report_mismatch("bit_count", 32'(got.bit_count), 32'(want.bit_count));
      if (got.data_byte !== want.data_byte)
        report_mismatch("data_byte", 32'(got.data_byte), 32'(want.data_byte));
      if (got.byte_index !== want.byte_index)
        report_mismatch("byte_index", 32'(got.byte_index), 32'(want.byte_index));
      if (got.last !== want.last)
        report_mismatch("last", 32'(got.last), 32'(want.last));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      stuck_cycles = 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_request(in_data);
        taken_cnt++;
        in_taken = 1'b1;
      end
      if (out_valid && out_ready) check_result(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
        if (stuck_cycles >= STALL_LIMIT) begin
          $display("tb: failure");
          $finish;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || in_taken) begin
        in_taken = 1'b0;
        if (hold_in > 0) begin
          hold_in--;
          in_valid <= 1'b0;
        end else if (request_q.size() > 0) begin
          in_data <= request_q.pop_front();
          in_valid <= 1'b1;
          if (!quiet && $urandom_range(0, 5) == 0) hold_in = $urandom_range(1, 6);
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (hold_out > 0) begin
        hold_out--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        hold_out = $urandom_range(1, 6) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic push_req(input logic [2:0] op, input logic [5:0] lim);
    wbr_pkg::in_item_t r;
    r.op = op;
    r.read_limit = lim;
    request_q.push_back(r);
    sent_cnt++;
  endtask

  task automatic queue_ticks(input int n);
    repeat (n) push_req(wbr_pkg::OP_TICK, 6'($urandom));
  endtask

  task automatic queue_pulse();
    push_req($urandom_range(0, 1) ? wbr_pkg::OP_DATA1 : wbr_pkg::OP_DATA0, 6'($urandom));
  endtask

  task automatic queue_frame(input int nbits);
    int k;
    repeat (nbits) begin
      if ($urandom_range(0, 9) == 0) push_req(3'($urandom_range(0, OP_SPARE_HI)), 6'($urandom));
      k = (gap_min_q > TICK_CAP) ? TICK_CAP : gap_min_q;
      if (k > 0 && $urandom_range(0, 7) == 0) k = $urandom_range(0, k - 1);
      queue_ticks(k);
      queue_pulse();
    end
    k = (timeout_q >= TICK_CAP) ? TICK_CAP : timeout_q + 1;
    if ($urandom_range(0, 5) == 0) k = $urandom_range(0, k);
    queue_ticks(k);
    if ($urandom_range(0, 2) == 0) push_req(wbr_pkg::OP_STATUS, 6'($urandom));
    push_req(wbr_pkg::OP_READ, ($urandom_range(0, 3) == 0) ? 6'($urandom)
                               : 6'($urandom_range(nbits / 8 + 1, LIMIT_MAX)));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (taken_cnt != sent_cnt || expected_q.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == wbr_pkg::REG_MIN_GAP) gap_min_q = value;
    else timeout_q = value;
    @(posedge clk);
  endtask

  task automatic set_timing(input logic [15:0] gap_v, input logic [15:0] timeout_v);
    write_reg(wbr_pkg::REG_MIN_GAP, gap_v);
    write_reg(wbr_pkg::REG_TIMEOUT, timeout_v);
  endtask

  initial begin
    int          base;
    int          phase;
    logic [8:0]  pattern;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    gap_min_q = wbr_pkg::MIN_GAP_RST;
    timeout_q = wbr_pkg::TIMEOUT_RST;
    idle_ticks = wbr_pkg::GAP_MAX;
    bits_held_q = '0;
    foreach (frame_q[i]) frame_q[i] = '0;
    sent_cnt = 0;
    taken_cnt = 0;
    errors = 0;
    stuck_cycles = 0;
    hold_in = 0;
    hold_out = 0;
    in_taken = 1'b0;
    quiet = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    push_req(wbr_pkg::OP_TICK, 6'd0);
    push_req(wbr_pkg::OP_STATUS, LIMIT_MAX);
    push_req(wbr_pkg::OP_READ, 6'd0);
    for (int c = OP_SPARE_LO; c <= OP_SPARE_HI; c++) push_req(3'(c), 6'($urandom));
    push_req(wbr_pkg::OP_DATA1, 6'd0);
    push_req(wbr_pkg::OP_DATA0, 6'd0);
    push_req(wbr_pkg::OP_STATUS, 6'd0);
    push_req(wbr_pkg::OP_READ, LIMIT_MAX);
    wait_drained();
    set_timing(16'd0, 16'd0);
    push_req(wbr_pkg::OP_TICK, 6'd0);
    push_req(wbr_pkg::OP_STATUS, 6'd0);
    push_req(wbr_pkg::OP_READ, 6'd1);
    pattern = 9'b101001110;
    for (int i = 8; i >= 0; i--) begin
      push_req(pattern[i] ? wbr_pkg::OP_DATA1 : wbr_pkg::OP_DATA0, 6'($urandom));
    end
    push_req(wbr_pkg::OP_TICK, 6'd0);
    push_req(wbr_pkg::OP_READ, 6'd32);
    wait_drained();

    // hold the frame back with the largest timeout, then release it
    set_timing(16'd1, wbr_pkg::GAP_MAX);
    push_req(wbr_pkg::OP_DATA1, 6'd0);
    push_req(wbr_pkg::OP_TICK, 6'd0);
    push_req(wbr_pkg::OP_DATA0, 6'd0);
    push_req(wbr_pkg::OP_TICK, 6'd0);
    push_req(wbr_pkg::OP_DATA1, 6'd0);
    queue_ticks(6);
    push_req(wbr_pkg::OP_STATUS, 6'd0);
    push_req(wbr_pkg::OP_READ, 6'd4);
    wait_drained();
    write_reg(wbr_pkg::REG_TIMEOUT, 16'd5);
    push_req(wbr_pkg::OP_STATUS, 6'd0);
    push_req(wbr_pkg::OP_READ, LIMIT_MAX);
    wait_drained();

    // overfill the buffer
    set_timing(16'd0, 16'd1);
    repeat (260) queue_pulse();
    queue_ticks(2);
    push_req(wbr_pkg::OP_STATUS, 6'd0);
    push_req(wbr_pkg::OP_READ, LIMIT_MAX);

    base = sent_cnt;
    phase = 0;
    while (sent_cnt - base < RAND_ITEMS) begin
      wait_drained();
      case (phase)
        0: set_timing(16'd0, 16'd0);
        1: set_timing(16'hFFFF, 16'd2);
        2: set_timing(16'd2, 16'hFFFF);
        3: set_timing(16'd1, 16'd3);
        default: begin
          if ($urandom_range(0, 3) == 0) set_timing(16'($urandom), 16'($urandom));
          else set_timing(16'($urandom_range(0, 4)), 16'($urandom_range(0, 8)));
        end
      endcase
      quiet = (sent_cnt - base >= QUIET_AFTER) || ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 4) == 0) queue_frame($urandom_range(0, 1) ? 26 : 34);
      else queue_frame($urandom_range(1, 16));
      phase++;
    end
    quiet = 1'b1;
    queue_frame(12);
    wait_drained();
    repeat (20) @(posedge clk);
    @(negedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
